// ----- rtl/core/tpc_pkg.sv -----
// Shared types and constants for the tilt PID controller.
`timescale 1ns / 1ps

package tpc_pkg;

    localparam int ACC_W  = 48;
    localparam int PROD_W = 43;
    localparam int MA_W   = 25;
    localparam int MB_W   = 18;

    // dt = 0.1 in Q0.16
    localparam logic signed [MB_W-1:0] DT_Q16 = 18'sd6554;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic signed [25:0] INT_LIMIT_POS = 26'sd12800000;
    localparam logic signed [25:0] INT_LIMIT_NEG = -26'sd12800000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GDT,
        ST_PRED,
        ST_P,
        ST_ANG,
        ST_ADT,
        ST_INT,
        ST_KP,
        ST_DRV
    } t_state;

    typedef enum logic [2:0] {
        MUL_GYRO_DT,
        MUL_ALPHA_ACC,
        MUL_BETA_PRED,
        MUL_KD_GYRO,
        MUL_ANG_DT,
        MUL_KP_ANG,
        MUL_KI_INT
    } t_mul_sel;

    typedef enum logic [2:0] {
        REG_KP     = 3'd0,
        REG_KD     = 3'd1,
        REG_KI     = 3'd2,
        REG_ALPHA  = 3'd3,
        REG_OFFSET = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic     in_load;
        t_mul_sel mul_sel;
        logic     pred_en;
        logic     acc_ld16;
        logic     ang_en;
        logic     acc_ld8;
        logic     integ_en;
        logic     acc_add;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

// ----- rtl/core/tpc_ctrl.sv -----
// Sequencer that steps one sample through the shared multiplier.
`timescale 1ns / 1ps

module tpc_ctrl
    import tpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   drv_done;
    logic   ready;

    assign drv_done = (r_state == ST_DRV) && !i_status.out_busy;
    assign ready    = (r_state == ST_IDLE) || drv_done;
    assign o_s_tready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_s_tvalid) n_state = ST_GDT;
            ST_GDT:  n_state = ST_PRED;
            ST_PRED: n_state = ST_P;
            ST_P:    n_state = ST_ANG;
            ST_ANG:  n_state = ST_ADT;
            ST_ADT:  n_state = ST_INT;
            ST_INT:  n_state = ST_KP;
            ST_KP:   n_state = ST_DRV;
            ST_DRV: begin
                // hold until the output register frees up
                if (drv_done) n_state = i_s_tvalid ? ST_GDT : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_GYRO_DT;
        o_cmd.in_load  = ready && i_s_tvalid;
        case (r_state)
            ST_PRED: begin
                o_cmd.mul_sel = MUL_ALPHA_ACC;
                o_cmd.pred_en = 1'b1;
            end
            ST_P: begin
                o_cmd.mul_sel  = MUL_BETA_PRED;
                o_cmd.acc_ld16 = 1'b1;
            end
            ST_ANG: begin
                o_cmd.mul_sel = MUL_KD_GYRO;
                o_cmd.ang_en  = 1'b1;
            end
            ST_ADT: begin
                o_cmd.mul_sel = MUL_ANG_DT;
                o_cmd.acc_ld8 = 1'b1;
            end
            ST_INT: begin
                o_cmd.mul_sel  = MUL_KP_ANG;
                o_cmd.integ_en = 1'b1;
            end
            ST_KP: begin
                o_cmd.mul_sel = MUL_KI_INT;
                o_cmd.acc_add = 1'b1;
            end
            ST_DRV: begin
                // keep the last product steady while stalled
                o_cmd.mul_sel  = MUL_KI_INT;
                o_cmd.out_load = drv_done;
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/tpc_datapath.sv -----
// Config registers, shared multiplier, accumulator, filter/PID state and output register.
`timescale 1ns / 1ps

module tpc_datapath
    import tpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic [31:0] i_s_tdata,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [87:0] o_m_tdata
);

    logic signed [15:0] r_kp, r_kd, r_ki, r_offset;
    logic [16:0]        r_alpha;

    logic signed [16:0]       r_accel;
    logic signed [15:0]       r_gyro;
    logic signed [24:0]       r_pred;
    logic signed [23:0]       r_est;
    logic signed [24:0]       r_integ;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic               r_out_valid;
    logic signed [31:0] r_left, r_right;
    logic signed [23:0] r_tilt;

    logic [16:0]              alpha_eff, beta;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  prod_x, acc_sum;
    logic signed [PROD_W-1:0] prod_rnd16;
    logic signed [24:0]       n_pred;
    logic signed [23:0]       n_est;
    logic signed [25:0]       integ_sum;
    logic signed [24:0]       n_integ;
    logic signed [31:0]       drive, drive_neg;
    logic                     acc_fits;
    logic signed [16:0]       accel_in;
    logic signed [15:0]       gyro_in;

    assign accel_in = {i_s_tdata[15], i_s_tdata[15:0]};
    assign gyro_in  = i_s_tdata[31:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= '0;
            r_kd     <= '0;
            r_ki     <= '0;
            r_alpha  <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KP:     r_kp     <= i_cfg_data[15:0];
                REG_KD:     r_kd     <= i_cfg_data[15:0];
                REG_KI:     r_ki     <= i_cfg_data[15:0];
                REG_ALPHA:  r_alpha  <= i_cfg_data;
                REG_OFFSET: r_offset <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign alpha_eff = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign beta      = ALPHA_ONE - alpha_eff;

    always_comb begin
        mul_a = {{9{r_gyro[15]}}, r_gyro};
        mul_b = DT_Q16;
        case (i_cmd.mul_sel)
            MUL_GYRO_DT: begin
                mul_a = {{9{r_gyro[15]}}, r_gyro};
                mul_b = DT_Q16;
            end
            MUL_ALPHA_ACC: begin
                mul_a = {{8{r_accel[16]}}, r_accel};
                mul_b = {1'b0, alpha_eff};
            end
            MUL_BETA_PRED: begin
                mul_a = r_pred;
                mul_b = {1'b0, beta};
            end
            MUL_KD_GYRO: begin
                mul_a = {{9{r_gyro[15]}}, r_gyro};
                mul_b = {{2{r_kd[15]}}, r_kd};
            end
            MUL_ANG_DT: begin
                mul_a = {r_est[23], r_est};
                mul_b = DT_Q16;
            end
            MUL_KP_ANG: begin
                mul_a = {r_est[23], r_est};
                mul_b = {{2{r_kp[15]}}, r_kp};
            end
            MUL_KI_INT: begin
                mul_a = r_integ;
                mul_b = {{2{r_ki[15]}}, r_ki};
            end
            default: ;
        endcase
    end

    assign n_prod = mul_a * mul_b;

    assign prod_x     = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign acc_sum    = r_acc + prod_x;
    assign acc_fits   = (acc_sum[47:39] == '0) || (acc_sum[47:39] == '1);
    assign prod_rnd16 = r_prod + 43'sd32768;

    // gyro prediction: previous estimate plus rounded gyro * dt
    assign n_pred = {r_est[23], r_est} + prod_rnd16[40:16];

    always_comb begin
        if (acc_fits) begin
            n_est = acc_sum[39:16];
        end else if (acc_sum[47]) begin
            n_est = 24'sh800000;
        end else begin
            n_est = 24'sh7FFFFF;
        end
    end

    assign integ_sum = {r_integ[24], r_integ} + {{5{prod_rnd16[36]}}, prod_rnd16[36:16]};

    always_comb begin
        if (integ_sum > INT_LIMIT_POS) begin
            n_integ = INT_LIMIT_POS[24:0];
        end else if (integ_sum < INT_LIMIT_NEG) begin
            n_integ = INT_LIMIT_NEG[24:0];
        end else begin
            n_integ = integ_sum[24:0];
        end
    end

    always_comb begin
        if (acc_fits) begin
            drive = acc_sum[39:8];
        end else if (acc_sum[47]) begin
            drive = 32'sh80000000;
        end else begin
            drive = 32'sh7FFFFFFF;
        end
        // negating the minimum saturates to the maximum
        drive_neg = (drive == 32'sh80000000) ? 32'sh7FFFFFFF : -drive;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_cmd.in_load) begin
            r_accel <= accel_in - {r_offset[15], r_offset};
            r_gyro  <= gyro_in;
        end
        if (i_cmd.pred_en) r_pred <= n_pred;
        if (i_cmd.acc_ld16) begin
            r_acc <= prod_x + 48'sd32768;
        end else if (i_cmd.acc_ld8) begin
            r_acc <= prod_x + 48'sd128;
        end else if (i_cmd.acc_add) begin
            r_acc <= acc_sum;
        end
        if (i_cmd.out_load) begin
            r_left  <= drive;
            r_right <= drive_neg;
            r_tilt  <= r_est;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est       <= '0;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ang_en)   r_est   <= n_est;
            if (i_cmd.integ_en) r_integ <= n_integ;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_busy = r_out_valid && !i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_tilt, r_right, r_left};

endmodule

// ----- rtl/core/tilt_pid_complementary.sv -----
// Top level of the tilt PID controller with complementary filter.
//
//  channel  direction  payload (lsb first)                     accepted when
//  s        in         accel_sample[15:0], gyro_rate[31:16]    i_s_tvalid & o_s_tready
//  m        out        left[31:0], right[63:32], tilt[87:64]   o_m_tvalid & i_m_tready
//  cfg      in         index[2:0], data[16:0]                  i_cfg_valid & o_cfg_ready
//
// Seven products go one per cycle through a single 25x18 multiplier, and the drive
// result lands in the output register last.
// A new sample is taken in the cycle the previous result is loaded.
// Synchronous active-low reset clears the angle estimate, the integral and all gains.
// If the prior result is still unread, the sequencer holds in its final step.
`timescale 1ns / 1ps

module tilt_pid_complementary
    import tpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // accel_sample[15:0], gyro_rate[31:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [87:0] o_m_tdata,   // left_drive[31:0], right_drive[63:32], tilt_angle[87:64]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    tpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tpc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
